FILE: sv/sfd_pkg.sv
// Package for the SLIP frame decoder: payload structs, SLIP character codes,
// status and class codes, and frame size limits. No dependencies.
package sfd_pkg;

    localparam int MAX_FRAME   = 1024;
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int LEN_W       = 11;
    localparam int MIN_FRAME   = 3;
    localparam int LEARN_LEN   = 40;

    localparam logic [7:0] SLIP_END     = 8'hc0;
    localparam logic [7:0] SLIP_ESC     = 8'hdb;
    localparam logic [7:0] SLIP_ESC_END = 8'hdc;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hdd;
    localparam logic [7:0] TYPE_MASK    = 8'hf0;
    localparam logic [7:0] TYPE_IPV4    = 8'h40;
    localparam logic [7:0] TYPE_UNCOMP  = 8'h70;
    localparam logic [7:0] UNCOMP_FIX   = 8'h4f;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_SHORT     = 2'd1,
        ST_DISCARDED = 2'd2,
        ST_REJECTED  = 2'd3
    } frame_status_t;

    typedef enum logic [1:0] {
        CL_IPV4   = 2'd0,
        CL_COMP   = 2'd1,
        CL_UNCOMP = 2'd2,
        CL_OTHER  = 2'd3
    } frame_class_t;

    typedef enum logic {
        CFG_COMPRESS_ENABLE = 1'b0,
        CFG_AUTO_COMPRESS   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } sfd_in_t;

    typedef struct packed {
        logic             is_frame_end;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
        logic [1:0]       frame_status;
        logic [1:0]       frame_class;
        logic [7:0]       first_byte_fixed;
        logic [31:0]      good_frames;
        logic [31:0]      input_errors;
    } sfd_out_t;

endpackage

FILE: sv/slip_frame_decoder.sv
// SLIP receive deframer: unescapes line bytes, emits payload bytes and a
// frame-end summary per frame. Depends on sfd_pkg.
//
// Each result is registered into the output register, or into the skid entry
// when the output is held. Throughput: one byte per cycle while the skid entry
// is empty; a two-entry output register (main + skid) absorbs one stalled result.
// Reset: all control state, counters and learned compression clear; the
// compression-enable register resets to 0 and auto-compress to 1.
module slip_frame_decoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sfd_pkg::sfd_in_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sfd_pkg::sfd_out_t out_data,
    input  logic            cfg_write_en,
    input  logic            cfg_index,
    input  logic            cfg_wdata
);
    import sfd_pkg::*;

    logic             compress_enable_reg;
    logic             auto_compress_reg;
    logic             escape_pending_reg, escape_pending_next;
    logic             error_pending_reg, error_pending_next;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [7:0]       first_stored_reg, first_stored_next;
    logic             compress_learned_reg, compress_learned_next;
    logic [31:0]      good_count_reg, good_count_next;
    logic [31:0]      error_count_reg, error_count_next;

    logic             out_valid_reg;
    sfd_out_t         out_data_reg;
    logic             skid_valid_reg;
    sfd_out_t         skid_data_reg;

    logic             in_xfer;
    logic             out_take;
    logic             res_valid;
    sfd_out_t         res;

    logic [7:0]       c;
    logic [7:0]       hi;
    logic             comp_on;
    frame_class_t     cls;
    frame_status_t    status;
    logic [7:0]       first_fixed;

    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Frame classification from the first stored byte
    always_comb
    begin
        hi      = first_stored_reg & TYPE_MASK;
        comp_on = compress_enable_reg || compress_learned_reg;
        first_fixed = first_stored_reg;
        if (hi == TYPE_IPV4)
        begin
            cls = CL_IPV4;
        end
        else if (hi[7])
        begin
            cls = CL_COMP;
        end
        else if (hi == TYPE_UNCOMP)
        begin
            cls = CL_UNCOMP;
            first_fixed = first_stored_reg & UNCOMP_FIX;
        end
        else
        begin
            cls = CL_OTHER;
        end
    end

    always_comb
    begin
        escape_pending_next   = escape_pending_reg;
        error_pending_next    = error_pending_reg;
        stored_count_next     = stored_count_reg;
        first_stored_next     = first_stored_reg;
        compress_learned_next = compress_learned_reg;
        good_count_next       = good_count_reg;
        error_count_next      = error_count_reg;
        res_valid             = 1'b0;
        res                   = '0;
        status                = ST_ACCEPTED;
        c                     = in_data.rx_byte;

        if (in_xfer)
        begin
            priority if (in_data.line_error)
            begin
                error_pending_next = 1'b1;
            end
            else if (in_data.rx_byte == SLIP_ESC)
            begin
                escape_pending_next = 1'b1;
            end
            else if (in_data.rx_byte == SLIP_END)
            begin
                res_valid = 1'b1;
                res.is_frame_end = 1'b1;
                res.frame_length = LEN_W'(stored_count_reg);
                if (error_pending_reg)
                begin
                    error_pending_next = 1'b0;
                    status = ST_DISCARDED;
                end
                else if (stored_count_reg < CNT_W'(MIN_FRAME))
                begin
                    status = ST_SHORT;
                end
                else
                begin
                    res.frame_class      = cls;
                    res.first_byte_fixed = first_fixed;
                    priority if (cls == CL_IPV4)
                        status = ST_ACCEPTED;
                    else if (cls == CL_OTHER)
                        status = ST_REJECTED;
                    else if (comp_on)
                        status = ST_ACCEPTED;
                    else if (auto_compress_reg && cls == CL_UNCOMP
                             && stored_count_reg >= CNT_W'(LEARN_LEN))
                    begin
                        status = ST_ACCEPTED;
                        compress_learned_next = 1'b1;
                    end
                    else
                        status = ST_REJECTED;
                    if (status == ST_ACCEPTED)
                        good_count_next = good_count_reg + 32'd1;
                    else
                        error_count_next = error_count_reg + 32'd1;
                end
                res.frame_status    = status;
                stored_count_next   = '0;
                escape_pending_next = 1'b0;
            end
            else
            begin
                if (escape_pending_reg)
                begin
                    if (in_data.rx_byte == SLIP_ESC_ESC)
                        c = SLIP_ESC;
                    else if (in_data.rx_byte == SLIP_ESC_END)
                        c = SLIP_END;
                end
                if (stored_count_reg < CNT_W'(MAX_FRAME))
                begin
                    if (stored_count_reg == '0)
                        first_stored_next = c;
                    stored_count_next   = stored_count_reg + CNT_W'(1);
                    escape_pending_next = 1'b0;
                    res_valid           = 1'b1;
                    res.data_byte       = c;
                end
                else
                begin
                    // Overflow: drop the byte and poison the rest of the frame
                    error_pending_next  = 1'b1;
                    error_count_next    = error_count_reg + 32'd1;
                    stored_count_next   = '0;
                    escape_pending_next = 1'b0;
                end
            end
            res.good_frames  = good_count_next;
            res.input_errors = error_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compress_enable_reg  <= 1'b0;
            auto_compress_reg    <= 1'b1;
            escape_pending_reg   <= 1'b0;
            error_pending_reg    <= 1'b0;
            stored_count_reg     <= '0;
            compress_learned_reg <= 1'b0;
            good_count_reg       <= '0;
            error_count_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_COMPRESS_ENABLE: compress_enable_reg <= cfg_wdata;
                    CFG_AUTO_COMPRESS:   auto_compress_reg   <= cfg_wdata;
                    default:             ;
                endcase
            end
            escape_pending_reg   <= escape_pending_next;
            error_pending_reg    <= error_pending_next;
            stored_count_reg     <= stored_count_next;
            compress_learned_reg <= compress_learned_next;
            good_count_reg       <= good_count_next;
            error_count_reg      <= error_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_stored_reg <= first_stored_next;
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_data_reg <= res;
            else
                skid_data_reg <= res;
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_W'(MAX_FRAME))
        else $error("stored count beyond frame limit");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.is_frame_end) |->
            (out_data_reg.frame_length == '0 && out_data_reg.frame_status == '0))
        else $error("payload result carries frame-end fields");

    a_learn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        compress_learned_reg |=> compress_learned_reg)
        else $error("learned compression cleared");

endmodule
